[rtl/core/i2c_master_bit_engine_assert.svh]
// ----------------------------------------------------------------------------
// i2c master bit engine assertion macros
// concurrent assertion wrappers, empty when SYNTHESIS is defined
// ----------------------------------------------------------------------------
`ifndef I2C_MASTER_BIT_ENGINE_ASSERT_SVH
`define I2C_MASTER_BIT_ENGINE_ASSERT_SVH

`ifndef SYNTHESIS
`define I2CM_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("i2cm assertion failed");
`define I2CM_ASSERT_ALWAYS(lbl, clk, prop) \
   lbl: assert property (@(posedge clk) prop) \
      else $error("i2cm assertion failed");
`else
`define I2CM_ASSERT(lbl, clk, rst, prop)
`define I2CM_ASSERT_ALWAYS(lbl, clk, prop)
`endif

`endif

[rtl/core/i2cm_pkg.sv]
// ----------------------------------------------------------------------------
// i2cm_pkg
// shared types and codes of the i2c master bit engine
// ----------------------------------------------------------------------------
package i2cm_pkg;

   localparam logic [2:0] CMD_NONE  = 3'd0;
   localparam logic [2:0] CMD_START = 3'd1;
   localparam logic [2:0] CMD_STOP  = 3'd2;
   localparam logic [2:0] CMD_WRITE = 3'd3;
   localparam logic [2:0] CMD_READ  = 3'd4;

   localparam logic CSR_PHASE_TICKS = 1'b0;
   localparam logic CSR_ACK_TIMEOUT = 1'b1;

   localparam logic [7:0] PHASE_TICKS_RESET = 8'd1;
   localparam logic [7:0] ACK_TIMEOUT_RESET = 8'd200;
   localparam logic [3:0] BITS_PER_BYTE     = 4'd8;

   typedef enum logic [4:0] {
      PH_IDLE = 5'd0,
      PH_S1   = 5'd1,
      PH_S2   = 5'd2,
      PH_S3   = 5'd3,
      PH_S4   = 5'd4,
      PH_P1   = 5'd5,
      PH_P2   = 5'd6,
      PH_P3   = 5'd7,
      PH_WHI  = 5'd8,
      PH_WLO  = 5'd9,
      PH_WNX  = 5'd10,
      PH_WAK  = 5'd11,
      PH_POLL = 5'd12,
      PH_FIN  = 5'd13,
      PH_RNX  = 5'd14,
      PH_RSM  = 5'd15,
      PH_RLO  = 5'd16
   } phase_type;

   typedef struct packed {
      logic [2:0] cmd;
      logic [7:0] write_data;
      logic       wait_ack;
      logic       sda_in;
   } req_type;

   typedef struct packed {
      logic       scl_out;
      logic       sda_out;
      logic       busy_res;
      logic       done_res;
      logic       ack_ok;
      logic [7:0] read_data;
   } rsp_type;

endpackage

[rtl/core/i2c_master_bit_engine.sv]
// ----------------------------------------------------------------------------
// i2c_master_bit_engine
// each accepted tick item gives a registered result item in the next cycle
// throughput: one item per cycle, limited only by the single result register
// a stalled result register stalls the input; each item is one timing tick
// synchronous reset: sequencer idle, pins released, phase_ticks 1,
// ack_timeout 200, no result pending
// ----------------------------------------------------------------------------
module i2c_master_bit_engine (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  i2cm_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output i2cm_pkg::rsp_type rsp_data,
   input  logic              csr_we,
   input  logic              csr_index,
   input  logic [7:0]        csr_wdata
);
   import i2cm_pkg::*;

   logic [7:0] phase_ticks_val_ff;
   logic [7:0] ack_timeout_ff;
   logic       accept;
   logic       buf_stall;
   rsp_type    next_rsp;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ticks_val_ff <= PHASE_TICKS_RESET;
         ack_timeout_ff     <= ACK_TIMEOUT_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CSR_PHASE_TICKS: phase_ticks_val_ff <= csr_wdata;
            CSR_ACK_TIMEOUT: ack_timeout_ff     <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   assign req_stall = buf_stall;
   assign accept    = req_valid & ~buf_stall;

   i2cm_seq u_seq (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .req         (req_data),
      .phase_ticks (phase_ticks_val_ff),
      .ack_timeout (ack_timeout_ff),
      .rsp         (next_rsp)
   );

   i2cm_rsp_buf u_rsp_buf (
      .clock     (clock),
      .reset     (reset),
      .load      (accept),
      .load_data (next_rsp),
      .in_stall  (buf_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

[rtl/core/i2cm_seq.sv]
// ----------------------------------------------------------------------------
// i2cm_seq
// pin sequencer state and next-state logic, one step per accepted item
// ----------------------------------------------------------------------------
`include "i2c_master_bit_engine_assert.svh"

module i2cm_seq (
   input  logic             clock,
   input  logic             reset,
   input  logic             accept,
   input  i2cm_pkg::req_type req,
   input  logic [7:0]       phase_ticks,
   input  logic [7:0]       ack_timeout,
   output i2cm_pkg::rsp_type rsp
);
   import i2cm_pkg::*;

   phase_type  phase_ff, phase_in;
   logic [3:0] bit_ff, bit_in;
   logic [7:0] shift_ff, shift_in;
   logic [7:0] delay_ff, delay_in;
   logic [7:0] poll_ff, poll_in;
   logic       scl_ff, scl_in;
   logic       sda_ff, sda_in;
   logic       ack_ff, ack_in;
   logic       wanted_ff, wanted_in;
   logic [7:0] rbyte_ff, rbyte_in;
   logic       done;
   logic [7:0] go_delay;

   assign go_delay = (phase_ticks == 8'd0) ? 8'd1 : phase_ticks;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_IDLE;
         bit_ff    <= 4'd0;
         shift_ff  <= 8'd0;
         delay_ff  <= 8'd0;
         poll_ff   <= 8'd0;
         scl_ff    <= 1'b1;
         sda_ff    <= 1'b1;
         ack_ff    <= 1'b0;
         wanted_ff <= 1'b0;
         rbyte_ff  <= 8'd0;
      end else if (accept) begin
         phase_ff  <= phase_in;
         bit_ff    <= bit_in;
         shift_ff  <= shift_in;
         delay_ff  <= delay_in;
         poll_ff   <= poll_in;
         scl_ff    <= scl_in;
         sda_ff    <= sda_in;
         ack_ff    <= ack_in;
         wanted_ff <= wanted_in;
         rbyte_ff  <= rbyte_in;
      end
   end

   always_comb begin
      phase_in  = phase_ff;
      bit_in    = bit_ff;
      shift_in  = shift_ff;
      delay_in  = delay_ff;
      poll_in   = poll_ff;
      scl_in    = scl_ff;
      sda_in    = sda_ff;
      ack_in    = ack_ff;
      wanted_in = wanted_ff;
      rbyte_in  = rbyte_ff;
      done      = 1'b0;
      if (phase_ff == PH_IDLE) begin
         case (req.cmd)
            CMD_START: begin
               sda_in   = 1'b1;
               phase_in = PH_S1;
               delay_in = go_delay;
            end
            CMD_STOP: begin
               sda_in   = 1'b0;
               phase_in = PH_P1;
               delay_in = go_delay;
            end
            CMD_WRITE: begin
               wanted_in = req.wait_ack;
               sda_in    = req.write_data[7];
               shift_in  = {req.write_data[6:0], 1'b0};
               bit_in    = 4'd1;
               phase_in  = PH_WHI;
               delay_in  = go_delay;
            end
            CMD_READ: begin
               sda_in   = 1'b1;
               shift_in = 8'd0;
               bit_in   = 4'd0;
               phase_in = PH_RNX;
               delay_in = go_delay;
            end
            default: begin
            end
         endcase
      end else if (phase_ff == PH_POLL) begin
         if (!req.sda_in || !wanted_ff) begin
            scl_in   = 1'b0;
            ack_in   = 1'b1;
            phase_in = PH_FIN;
            delay_in = go_delay;
         end else if (poll_ff >= ack_timeout) begin
            scl_in   = 1'b0;
            ack_in   = 1'b0;
            phase_in = PH_FIN;
            delay_in = go_delay;
         end else begin
            poll_in = poll_ff + 8'd1;
         end
      end else if (delay_ff > 8'd1) begin
         delay_in = delay_ff - 8'd1;
      end else begin
         delay_in = go_delay;
         case (phase_ff)
            PH_S1: begin
               scl_in   = 1'b1;
               phase_in = PH_S2;
            end
            PH_S2: begin
               sda_in   = 1'b0;
               phase_in = PH_S3;
            end
            PH_S3: begin
               scl_in   = 1'b0;
               phase_in = PH_S4;
            end
            PH_P1: begin
               scl_in   = 1'b1;
               phase_in = PH_P2;
            end
            PH_P2: begin
               sda_in   = 1'b1;
               phase_in = PH_P3;
            end
            PH_WHI: begin
               scl_in   = 1'b1;
               phase_in = PH_WLO;
            end
            PH_WLO: begin
               scl_in   = 1'b0;
               phase_in = PH_WNX;
            end
            PH_WNX: begin
               if (bit_ff < BITS_PER_BYTE) begin
                  sda_in   = shift_ff[7];
                  shift_in = {shift_ff[6:0], 1'b0};
                  bit_in   = bit_ff + 4'd1;
                  phase_in = PH_WHI;
               end else begin
                  sda_in   = 1'b1;
                  phase_in = PH_WAK;
               end
            end
            PH_WAK: begin
               scl_in   = 1'b1;
               poll_in  = 8'd0;
               phase_in = PH_POLL;
               delay_in = 8'd0;
            end
            PH_RNX: begin
               if (bit_ff < BITS_PER_BYTE) begin
                  scl_in   = 1'b1;
                  phase_in = PH_RSM;
               end else begin
                  rbyte_in = shift_ff;
                  phase_in = PH_IDLE;
                  delay_in = 8'd0;
                  done     = 1'b1;
               end
            end
            PH_RSM: begin
               shift_in = {shift_ff[6:0], req.sda_in};
               bit_in   = bit_ff + 4'd1;
               phase_in = PH_RLO;
            end
            PH_RLO: begin
               scl_in   = 1'b0;
               phase_in = PH_RNX;
            end
            default: begin
               // end of start, stop or write
               phase_in = PH_IDLE;
               delay_in = 8'd0;
               done     = 1'b1;
            end
         endcase
      end
   end

   always_comb begin
      rsp.scl_out   = scl_in;
      rsp.sda_out   = sda_in;
      rsp.busy_res  = (phase_in != PH_IDLE);
      rsp.done_res  = done;
      rsp.ack_ok    = ack_in;
      rsp.read_data = rbyte_in;
   end

   `I2CM_ASSERT(a_done_to_idle, clock, reset, accept && done |=> phase_ff == PH_IDLE)
   `I2CM_ASSERT(a_bit_range, clock, reset, bit_ff <= BITS_PER_BYTE)
   `I2CM_ASSERT(a_delay_armed, clock, reset,
      (phase_ff != PH_IDLE && phase_ff != PH_POLL) |-> delay_ff != 8'd0)
   `I2CM_ASSERT_ALWAYS(a_reset_released, clock,
      reset |=> (phase_ff == PH_IDLE && scl_ff && sda_ff))

endmodule

[rtl/core/i2cm_rsp_buf.sv]
// ----------------------------------------------------------------------------
// i2cm_rsp_buf
// result register that holds an item until the consumer takes it
// ----------------------------------------------------------------------------
module i2cm_rsp_buf (
   input  logic              clock,
   input  logic              reset,
   input  logic              load,
   input  i2cm_pkg::rsp_type load_data,
   output logic              in_stall,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output i2cm_pkg::rsp_type rsp_data
);
   import i2cm_pkg::*;

   logic    valid_ff, valid_in;
   rsp_type data_ff;

   assign in_stall = valid_ff & rsp_stall;
   assign valid_in = load | (valid_ff & rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= load_data;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_data  = data_ff;

endmodule

[sim/tb.sv]
// ----------------------------------------------------------------------------
// tb
// checks the i2c master bit engine tick by tick: every accepted tick item is
// run through a behavioral model of the scl/sda sequencer and the pin state,
// busy, done, acknowledge status and read byte of each result item are
// compared. directed start, stop, write, read and busy cases come first,
// then random command streams over several delay and timeout settings
// ----------------------------------------------------------------------------
module tb;
   import i2cm_pkg::*;

   localparam int LIMIT_CYCLES = 600000;
   localparam int HOLD_CYCLES = 90;
   localparam logic [2:0] CMD_BAD_LO = 3'd5;
   localparam logic [2:0] CMD_BAD_HI = 3'd7;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_stall;
   req_type    req_data = '0;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   rsp_type    rsp_data;
   logic       csr_we = 1'b0;
   logic       csr_index = 1'b0;
   logic [7:0] csr_wdata = 8'd0;

   req_type tick_q[$];
   rsp_type pins_due_q[$];

   // model state
   logic [7:0] cfg_phase_ticks;
   logic [7:0] cfg_ack_timeout;
   phase_type  eng_phase;
   logic [3:0] eng_bit;
   logic [7:0] eng_shift;
   logic [7:0] eng_delay;
   logic [7:0] eng_poll;
   logic       eng_scl;
   logic       eng_sda;
   logic       eng_ack;
   logic       eng_want_ack;
   logic [7:0] eng_rbyte;

   bit req_taken = 1'b0;
   bit no_idle = 1'b0;
   bit held = 1'b0;
   int hold_left = 0;
   int send_gap = 0;
   int recv_gap = 0;
   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int cycle_no = 0;
   int rsp_count = 0;
   int mismatches = 0;
   int n_planned = 0;
   int n_ticks = 0;
   int n_seq = 0;
   int n_ignored = 0;
   int n_nak = 0;

   i2c_master_bit_engine i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   function automatic void enter(input phase_type nx);
      eng_phase = nx;
      eng_delay = (cfg_phase_ticks == 8'd0) ? 8'd1 : cfg_phase_ticks;
   endfunction

   function automatic void shift_out_bit();
      eng_sda = eng_shift[7];
      eng_shift = eng_shift << 1;
      eng_bit = eng_bit + 4'd1;
      enter(PH_WHI);
   endfunction

   function automatic logic pin_step(input logic sda);
      logic fin;
      fin = 1'b0;
      case (eng_phase)
         PH_S1: begin
            eng_scl = 1'b1;
            enter(PH_S2);
         end
         PH_S2: begin
            eng_sda = 1'b0;
            enter(PH_S3);
         end
         PH_S3: begin
            eng_scl = 1'b0;
            enter(PH_S4);
         end
         PH_P1: begin
            eng_scl = 1'b1;
            enter(PH_P2);
         end
         PH_P2: begin
            eng_sda = 1'b1;
            enter(PH_P3);
         end
         PH_WHI: begin
            eng_scl = 1'b1;
            enter(PH_WLO);
         end
         PH_WLO: begin
            eng_scl = 1'b0;
            enter(PH_WNX);
         end
         PH_WNX: begin
            if (eng_bit < BITS_PER_BYTE) begin
               shift_out_bit();
            end else begin
               eng_sda = 1'b1;
               enter(PH_WAK);
            end
         end
         PH_WAK: begin
            eng_scl = 1'b1;
            eng_poll = 8'd0;
            eng_phase = PH_POLL;
            eng_delay = 8'd0;
         end
         PH_RNX: begin
            if (eng_bit < BITS_PER_BYTE) begin
               eng_scl = 1'b1;
               enter(PH_RSM);
            end else begin
               eng_rbyte = eng_shift;
               eng_phase = PH_IDLE;
               eng_delay = 8'd0;
               fin = 1'b1;
            end
         end
         PH_RSM: begin
            eng_shift = {eng_shift[6:0], sda};
            eng_bit = eng_bit + 4'd1;
            enter(PH_RLO);
         end
         PH_RLO: begin
            eng_scl = 1'b0;
            enter(PH_RNX);
         end
         default: begin
            eng_phase = PH_IDLE;
            eng_delay = 8'd0;
            fin = 1'b1;
         end
      endcase
      return fin;
   endfunction

   function automatic rsp_type sequencer_tick(input req_type r);
      rsp_type o;
      logic fin;
      fin = 1'b0;
      n_ticks++;
      if (eng_phase == PH_IDLE) begin
         case (r.cmd)
            CMD_START: begin
               eng_sda = 1'b1;
               enter(PH_S1);
            end
            CMD_STOP: begin
               eng_sda = 1'b0;
               enter(PH_P1);
            end
            CMD_WRITE: begin
               eng_shift = r.write_data;
               eng_want_ack = r.wait_ack;
               eng_bit = 4'd0;
               shift_out_bit();
            end
            CMD_READ: begin
               eng_sda = 1'b1;
               eng_shift = 8'd0;
               eng_bit = 4'd0;
               enter(PH_RNX);
            end
            default: ;
         endcase
         if (eng_phase != PH_IDLE)
            n_seq++;
      end else begin
         if (r.cmd != CMD_NONE)
            n_ignored++;
         if (eng_phase == PH_POLL) begin
            if (!r.sda_in || !eng_want_ack) begin
               eng_scl = 1'b0;
               eng_ack = 1'b1;
               enter(PH_FIN);
            end else if (eng_poll >= cfg_ack_timeout) begin
               eng_scl = 1'b0;
               eng_ack = 1'b0;
               n_nak++;
               enter(PH_FIN);
            end else begin
               eng_poll = eng_poll + 8'd1;
            end
         end else if (eng_delay > 8'd1) begin
            eng_delay = eng_delay - 8'd1;
         end else begin
            fin = pin_step(r.sda_in);
         end
      end
      o.scl_out = eng_scl;
      o.sda_out = eng_sda;
      o.busy_res = (eng_phase != PH_IDLE);
      o.done_res = fin;
      o.ack_ok = eng_ack;
      o.read_data = eng_rbyte;
      return o;
   endfunction

   function automatic void report_field(input string name, input logic [7:0] want,
                                        input logic [7:0] got);
      if (want !== got) begin
         $error("%s expected %0h actual %0h", name, want, got);
         mismatches++;
      end
   endfunction

   // ticks from a command to its done tick, worst case for acknowledge polling
   function automatic int seq_span(input logic [2:0] code, input logic wack);
      int p;
      p = (cfg_phase_ticks == 8'd0) ? 1 : int'(cfg_phase_ticks);
      case (code)
         CMD_START: return 4 * p;
         CMD_STOP:  return 3 * p;
         CMD_WRITE: return 26 * p + 1 + (wack ? int'(cfg_ack_timeout) : 0);
         CMD_READ:  return 25 * p;
         default:   return 0;
      endcase
   endfunction

   function automatic logic sda_draw(input int low_pct);
      return ($urandom_range(0, 99) < low_pct) ? 1'b0 : 1'b1;
   endfunction

   task automatic add_seq(input logic [2:0] code, input logic [7:0] data,
                          input logic wack, input int low_pct, input int fill);
      req_type t;
      int quiet;
      quiet = seq_span(code, 1'b0);
      t.cmd = code;
      t.write_data = data;
      t.wait_ack = wack;
      t.sda_in = sda_draw(low_pct);
      tick_q.push_back(t);
      for (int i = 1; i <= fill; i++) begin
         // stray commands only where the block is surely still busy
         if (i <= quiet && $urandom_range(0, 9) == 0)
            t.cmd = 3'($urandom_range(0, 7));
         else
            t.cmd = CMD_NONE;
         t.write_data = 8'($urandom);
         t.wait_ack = 1'($urandom);
         t.sda_in = sda_draw(low_pct);
         tick_q.push_back(t);
      end
      n_planned += fill + 1;
   endtask

   task automatic random_part(input int budget);
      int goal;
      int pick;
      int span;
      int fill;
      int owed;
      int low_pct;
      logic [2:0] code;
      logic wack;
      goal = n_planned + budget;
      owed = 0;
      while (n_planned < goal) begin
         pick = $urandom_range(0, 99);
         if (pick < 20)
            code = CMD_START;
         else if (pick < 40)
            code = CMD_STOP;
         else if (pick < 75)
            code = CMD_WRITE;
         else if (pick < 95)
            code = CMD_READ;
         else if (pick < 98)
            code = 3'($urandom_range(CMD_BAD_LO, CMD_BAD_HI));
         else
            code = CMD_NONE;
         wack = ($urandom_range(0, 9) < 7);
         low_pct = 50;
         if (code == CMD_WRITE) begin
            case ($urandom_range(0, 3))
               0: low_pct = 0;
               1: low_pct = 10;
               default: low_pct = 40;
            endcase
         end
         span = seq_span(code, wack);
         if (span > 3 && $urandom_range(0, 9) == 0) begin
            fill = span - $urandom_range(1, 3);
            owed = span - fill;
         end else begin
            fill = span + $urandom_range(0, 3);
            owed = 0;
         end
         add_seq(code, 8'($urandom), wack, low_pct, fill);
      end
      if (owed != 0)
         add_seq(CMD_NONE, 8'($urandom), 1'b0, 50, owed);
   endtask

   task automatic drain();
      do
         @(negedge clock);
      while (tick_q.size() != 0 || pins_due_q.size() != 0 || req_valid);
   endtask

   task automatic configure(input logic [7:0] ticks, input logic [7:0] timeout);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_index <= CSR_PHASE_TICKS;
      csr_wdata <= ticks;
      @(negedge clock);
      csr_index <= CSR_ACK_TIMEOUT;
      csr_wdata <= timeout;
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   // sender
   always @(negedge clock) begin
      if (!reset && !(req_valid && !req_taken)) begin
         if (send_gap != 0) begin
            send_gap <= send_gap - 1;
            req_valid <= 1'b0;
         end else if (!no_idle && hold_left == 0 &&
                      $urandom_range(0, 99) < send_idle_pct) begin
            send_gap <= $urandom_range(0, 6);
            req_valid <= 1'b0;
         end else if (tick_q.size() != 0) begin
            req_data <= tick_q.pop_front();
            req_valid <= 1'b1;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // receiver
   always @(negedge clock) begin
      if (!reset) begin
         if (!held && rsp_count >= 300 && tick_q.size() > 20) begin
            held <= 1'b1;
            hold_left <= HOLD_CYCLES;
            rsp_stall <= 1'b1;
         end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            rsp_stall <= 1'b1;
         end else if (recv_gap != 0) begin
            recv_gap <= recv_gap - 1;
            rsp_stall <= 1'b1;
         end else if (!no_idle && $urandom_range(0, 99) < recv_idle_pct) begin
            recv_gap <= $urandom_range(0, 6);
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // result check and prediction
   always @(posedge clock) begin
      rsp_type due;
      req_taken = !reset && req_valid && !req_stall;
      if (!reset) begin
         if (csr_we) begin
            case (csr_index)
               CSR_PHASE_TICKS: cfg_phase_ticks = csr_wdata;
               CSR_ACK_TIMEOUT: cfg_ack_timeout = csr_wdata;
               default: ;
            endcase
         end
         if (rsp_valid && !rsp_stall) begin
            rsp_count++;
            if (pins_due_q.size() == 0) begin
               $error("result item with no tick item pending");
               mismatches++;
            end else begin
               due = pins_due_q.pop_front();
               report_field("scl_out", 8'(due.scl_out), 8'(rsp_data.scl_out));
               report_field("sda_out", 8'(due.sda_out), 8'(rsp_data.sda_out));
               report_field("busy_res", 8'(due.busy_res), 8'(rsp_data.busy_res));
               report_field("done_res", 8'(due.done_res), 8'(rsp_data.done_res));
               report_field("ack_ok", 8'(due.ack_ok), 8'(rsp_data.ack_ok));
               report_field("read_data", due.read_data, rsp_data.read_data);
            end
         end
         if (req_taken)
            pins_due_q.push_back(sequencer_tick(req_data));
      end
   end

   // watchdog and idle rates
   always @(posedge clock) begin
      cycle_no++;
      if (cycle_no % 64 == 0) begin
         send_idle_pct <= $urandom_range(0, 3) * 12;
         recv_idle_pct <= $urandom_range(0, 3) * 12;
      end
      if (cycle_no >= LIMIT_CYCLES) begin
         $display("FAIL");
         $finish;
      end
   end

   initial begin
      cfg_phase_ticks = PHASE_TICKS_RESET;
      cfg_ack_timeout = ACK_TIMEOUT_RESET;
      eng_phase = PH_IDLE;
      eng_bit = 4'd0;
      eng_shift = 8'd0;
      eng_delay = 8'd0;
      eng_poll = 8'd0;
      eng_scl = 1'b1;
      eng_sda = 1'b1;
      eng_ack = 1'b0;
      eng_want_ack = 1'b0;
      eng_rbyte = 8'd0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed, reset settings
      for (int c = CMD_BAD_LO; c <= CMD_BAD_HI; c++)
         add_seq(3'(c), 8'hFF, 1'b1, 50, 1);
      add_seq(CMD_NONE, 8'h00, 1'b0, 50, 1);
      add_seq(CMD_START, 8'h00, 1'b0, 50, seq_span(CMD_START, 1'b0));
      add_seq(CMD_WRITE, 8'hFF, 1'b0, 0, seq_span(CMD_WRITE, 1'b0) + 1);
      add_seq(CMD_WRITE, 8'h00, 1'b1, 100, seq_span(CMD_WRITE, 1'b0));
      // no acknowledge: polls run out at the reset timeout
      add_seq(CMD_WRITE, 8'hA5, 1'b1, 0, seq_span(CMD_WRITE, 1'b1));
      add_seq(CMD_READ, 8'h00, 1'b0, 0, seq_span(CMD_READ, 1'b0));
      add_seq(CMD_READ, 8'hFF, 1'b1, 100, seq_span(CMD_READ, 1'b0));
      // next command lands on the done tick
      add_seq(CMD_START, 8'h00, 1'b0, 50, seq_span(CMD_START, 1'b0) - 1);
      add_seq(CMD_STOP, 8'h00, 1'b0, 50, 2);
      add_seq(CMD_STOP, 8'h00, 1'b0, 50, seq_span(CMD_STOP, 1'b0));
      // read issued in the middle of a write
      add_seq(CMD_WRITE, 8'h3C, 1'b1, 50, 5);
      add_seq(CMD_READ, 8'h00, 1'b0, 50, seq_span(CMD_WRITE, 1'b0));
      drain();

      configure(8'd1, 8'd0);
      random_part(40);
      drain();
      configure(8'd2, 8'd3);
      random_part(40);
      drain();
      configure(8'd0, 8'd1);
      random_part(30);
      drain();
      configure(8'd3, 8'd12);
      random_part(40);
      drain();

      // longer phases, a few full sequences only
      configure(8'd5, 8'd9);
      add_seq(CMD_START, 8'h00, 1'b0, 50, seq_span(CMD_START, 1'b0));
      add_seq(CMD_WRITE, 8'h5A, 1'b1, 0, seq_span(CMD_WRITE, 1'b1));
      add_seq(CMD_STOP, 8'h00, 1'b0, 50, seq_span(CMD_STOP, 1'b0));
      drain();

      no_idle = 1'b1;
      configure(8'd1, 8'd5);
      random_part(50);
      drain();
      repeat (4) @(posedge clock);

      $display("%0d tick items, %0d sequences run, %0d commands dropped while busy",
               n_ticks, n_seq, n_ignored);
      $display("%0d acknowledge timeouts; phase ticks 0 to 5, timeouts 0 to 200, one long hold",
               n_nak);
      if (mismatches == 0 && pins_due_q.size() == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule
